// ===== hw/rtl/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, constants and compare helpers shared by the 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  // Largest row the line memory holds, and the tallest frame supported.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int NUM_CHAN = 3;
  localparam int CHAN_W   = 8;

  // Register fields as the configuration port carries them.
  localparam int FW_FIELD_W = 12;
  localparam int FH_FIELD_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam logic [FW_FIELD_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [FH_FIELD_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // Counter and size widths.
  localparam int COL_W  = $clog2(MAX_WIDTH);       // column index
  localparam int W_W    = $clog2(MAX_WIDTH + 1);   // width in use
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);  // height in use
  localparam int OROW_W = $clog2(MAX_HEIGHT);      // output row
  localparam int IROW_W = $clog2(MAX_HEIGHT + 2);  // input row, runs one past during drain

  // Result queue behind the pipeline.
  localparam int FIFO_DEPTH = 8;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CHAN-1:0] pix_t;
  typedef chan_t [2:0] trio_t;
  // Window indexed [row][column]; row 0 is the oldest line, column 2 the newest pixel.
  typedef pix_t [2:0][2:0] win_t;

  // One line memory entry holds the pixel of both stored rows at one column.
  typedef struct packed {
    pix_t up2;
    pix_t up1;
  } line_t;

  typedef struct packed {
    logic  mode;
    chan_t chan0_in;
    chan_t chan1_in;
    chan_t chan2_in;
  } in_t;

  typedef struct packed {
    chan_t chan0_out;
    chan_t chan1_out;
    chan_t chan2_out;
    logic  frame_end;
  } res_t;

  function automatic logic [W_W-1:0] clamp_width(logic [FW_FIELD_W-1:0] raw);
    logic [W_W-1:0] w;
    if (32'(raw) < 3) begin
      w = W_W'(3);
    end else if (32'(raw) > MAX_WIDTH) begin
      w = W_W'(MAX_WIDTH);
    end else begin
      w = W_W'(raw);
    end
    return w;
  endfunction

  function automatic logic [H_W-1:0] clamp_height(logic [FH_FIELD_W-1:0] raw);
    logic [H_W-1:0] h;
    if (32'(raw) < 3) begin
      h = H_W'(3);
    end else if (32'(raw) > MAX_HEIGHT) begin
      h = H_W'(MAX_HEIGHT);
    end else begin
      h = H_W'(raw);
    end
    return h;
  endfunction

  function automatic chan_t max2(chan_t a, chan_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic chan_t min2(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  // Returns the three values in ascending order: [0] lowest, [2] highest.
  function automatic trio_t sort3(trio_t v);
    chan_t lo;
    chan_t hi;
    chan_t mid;
    trio_t r;
    lo   = min2(v[0], v[1]);
    hi   = max2(v[0], v[1]);
    r[2] = max2(hi, v[2]);
    mid  = min2(hi, v[2]);
    r[0] = min2(lo, mid);
    r[1] = max2(lo, mid);
    return r;
  endfunction

  function automatic chan_t max3(trio_t v);
    return max2(max2(v[0], v[1]), v[2]);
  endfunction

  function automatic chan_t min3(trio_t v);
    return min2(min2(v[0], v[1]), v[2]);
  endfunction

  function automatic chan_t med3(trio_t v);
    return max2(min2(v[0], v[1]), min2(max2(v[0], v[1]), v[2]));
  endfunction

endpackage

// ===== hw/rtl/mf3_ram.sv =====
// ----------------------------------------------------------------------------
// mf3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mf3_median.sv =====
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median of a 3x3 window, each color channel on its own.
// ----------------------------------------------------------------------------
module mf3_median (
  input  logic          clk,
  input  mf3_pkg::win_t win,
  output mf3_pkg::pix_t med
);

  import mf3_pkg::*;

  // Stage 1: each window row sorted. Stage 2: max of lows, median of middles,
  // min of highs. Stage 3: the median of those three is the median of nine.
  trio_t [NUM_CHAN-1:0][2:0] srt_r;
  trio_t [NUM_CHAN-1:0]      cand_r;
  pix_t                      med_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      for (int r = 0; r < 3; r++) begin
        srt_r[c][r] <= sort3({win[r][2][c], win[r][1][c], win[r][0][c]});
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      cand_r[c][0] <= max3({srt_r[c][2][0], srt_r[c][1][0], srt_r[c][0][0]});
      cand_r[c][1] <= med3({srt_r[c][2][1], srt_r[c][1][1], srt_r[c][0][1]});
      cand_r[c][2] <= min3({srt_r[c][2][2], srt_r[c][1][2], srt_r[c][0][2]});
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      med_r[c] <= med3(cand_r[c]);
    end
  end

  assign med = med_r;

endmodule

// ===== hw/rtl/median_filter_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb
// 3x3 median filter over a raster stream of RGB pixels, border passed through.
// Output: a result word follows the input word that completes its window,
//   i.e. one row plus one pixel later in the stream.
// Throughput: one input word per cycle while the result queue has room, set
//   by one line memory read and write per word; each drain word drains a result.
// Reset: counters cleared, size 640x480, window cleared; the line memory is
//   not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mf3_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mf3_pkg::res_t                      out_data,
  input  logic                               cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import mf3_pkg::*;

  // Frame size and position counters.
  logic [W_W-1:0]    w_r, w_nxt;
  logic [H_W-1:0]    h_r, h_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [IROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  logic       in_fire;
  logic       active;
  logic       proc;
  pix_t       pix;
  logic       emit;
  logic       border;
  logic       last;
  logic [W_W-1:0] col_inc;
  logic [W_W-1:0] ocol_inc;
  logic [H_W-1:0] orow_inc;

  // Stage 1: line memory data arrives, window shifts, memory written back.
  logic             s1_vld_r;
  logic             s1_emit_r;
  logic             s1_border_r;
  logic             s1_last_r;
  logic             s1_fwd_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] s1_col_r;

  line_t ram_rdata;
  line_t ram_wdata;
  line_t fwd_r;
  line_t up;
  win_t  window_r;

  // Stages 2..5 carry the side information next to the median unit.
  logic s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic s2_border_r, s3_border_r, s4_border_r, s5_border_r;
  logic s2_last_r, s3_last_r, s4_last_r, s5_last_r;
  pix_t s3_center_r, s4_center_r, s5_center_r;
  pix_t med;
  pix_t sel;
  res_t push_data;

  // Result queue.
  res_t              fifo_mem [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FCNT_W-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [FCNT_W-1:0] pipe_cnt;
  logic              push;
  logic              pop;

  // --------------------------------------------------------------------------
  // Accept stage: counters, emit and border decisions, memory read.
  // --------------------------------------------------------------------------
  assign in_fire = in_valid && in_ready;
  assign active  = in_row_r < IROW_W'(h_r);
  // A flush word during the frame is taken and dropped.
  assign proc    = in_fire && (!active || in_data.mode == MODE_PIXEL);
  assign pix     = active ? {in_data.chan2_in, in_data.chan1_in, in_data.chan0_in} : '0;

  assign col_inc  = W_W'(in_col_r) + W_W'(1);
  assign ocol_inc = W_W'(out_col_r) + W_W'(1);
  assign orow_inc = H_W'(out_row_r) + H_W'(1);

  assign emit   = (in_row_r >= IROW_W'(2)) || (in_row_r == IROW_W'(1) && in_col_r != '0);
  assign border = (out_row_r == '0) || (orow_inc >= h_r) || (out_col_r == '0)
               || (ocol_inc >= w_r);
  assign last   = (orow_inc >= h_r) && (ocol_inc >= w_r);

  always_comb begin
    w_nxt       = w_r;
    h_nxt       = h_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  w_nxt = clamp_width(cfg_wdata[FW_FIELD_W-1:0]);
        CFG_FRAME_HEIGHT: h_nxt = clamp_height(cfg_wdata[FH_FIELD_W-1:0]);
        default: ;
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (proc) begin
      if (col_inc >= w_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (last) begin
          // The frame's final result: everything restarts for the next frame.
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (ocol_inc >= w_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= clamp_width(RST_FRAME_WIDTH);
      h_r       <= clamp_height(RST_FRAME_HEIGHT);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: read at accept, write back in the next cycle. The only overlap
  // is a read of the column being written in the same cycle, which is
  // served from the forwarding register.
  // --------------------------------------------------------------------------
  mf3_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (proc),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= proc;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      s1_emit_r   <= emit;
      s1_border_r <= border;
      s1_last_r   <= last;
      s1_pix_r    <= pix;
      s1_col_r    <= in_col_r;
      s1_fwd_r    <= s1_vld_r && (s1_col_r == in_col_r);
    end
    fwd_r <= ram_wdata;
  end

  assign up            = s1_fwd_r ? fwd_r : ram_rdata;
  assign ram_wdata.up2 = up.up1;
  assign ram_wdata.up1 = s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_vld_r) begin
      for (int r = 0; r < 3; r++) begin
        window_r[r][0] <= window_r[r][1];
        window_r[r][1] <= window_r[r][2];
      end
      window_r[0][2] <= up.up2;
      window_r[1][2] <= up.up1;
      window_r[2][2] <= s1_pix_r;
    end
  end

  // --------------------------------------------------------------------------
  // Median unit and side pipeline.
  // --------------------------------------------------------------------------
  mf3_median u_median (
    .clk (clk),
    .win (window_r),
    .med (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && s1_emit_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_border_r <= s1_border_r;
    s2_last_r   <= s1_last_r;
    s3_border_r <= s2_border_r;
    s3_last_r   <= s2_last_r;
    s3_center_r <= window_r[1][1];
    s4_border_r <= s3_border_r;
    s4_last_r   <= s3_last_r;
    s4_center_r <= s3_center_r;
    s5_border_r <= s4_border_r;
    s5_last_r   <= s4_last_r;
    s5_center_r <= s4_center_r;
  end

  assign sel                 = s5_border_r ? s5_center_r : med;
  assign push_data.chan0_out = sel[0];
  assign push_data.chan1_out = sel[1];
  assign push_data.chan2_out = sel[2];
  assign push_data.frame_end = s5_last_r;

  // --------------------------------------------------------------------------
  // Result queue. A word is taken only when the queue has room for every
  // result already in flight, so the pipeline never stalls.
  // --------------------------------------------------------------------------
  assign push = s5_vld_r;
  assign pop  = out_valid && out_ready;

  assign pipe_cnt = FCNT_W'(s1_vld_r & s1_emit_r) + FCNT_W'(s2_vld_r) + FCNT_W'(s3_vld_r)
                  + FCNT_W'(s4_vld_r) + FCNT_W'(s5_vld_r);
  assign in_ready = (fifo_cnt_r + pipe_cnt) < FCNT_W'(FIFO_DEPTH);

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r;
    if (push && !pop) begin
      fifo_cnt_nxt = fifo_cnt_r + 1'b1;
    end else if (pop && !push) begin
      fifo_cnt_nxt = fifo_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = fifo_cnt_r != '0;
  assign out_data  = fifo_mem[rd_ptr_r];

`ifndef SYNTHESIS
  // Words in flight never outnumber the free queue slots.
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_cnt_r + pipe_cnt) <= FCNT_W'(FIFO_DEPTH))
    else $error("result queue credit exceeded");

  // The drain never runs more than one row past the frame.
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= IROW_W'(h_r) + IROW_W'(1))
    else $error("input row ran past the drain");

  // The last result of a frame sends every counter back to the start.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && emit && last && !cfg_we) |=>
      (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("frame did not restart after its last result");

  // The frame's last pixel always lies on the border.
  a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_vld_r && s5_last_r) |-> s5_border_r)
    else $error("frame end outside the border");
`endif

endmodule

// ===== verif/tb_median_filter_3x3_rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_rgb
// Streams RGB frames of many sizes through the 3x3 median filter, including
// the reset size, clamped sizes, restarts by register write, ignored flush
// words and drains, and checks every result word against a behavioral model
// of the filter. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_rgb;
  import mf3_pkg::*;

  localparam int IDLE_GAP      = 20;    // cycles allowed after the last result
  localparam int QUIET_LIMIT   = 1000;  // cycles without any accepted word
  localparam int RANDOM_PIXELS = 600;
  localparam int PRINT_CAP     = 200;

  typedef enum int {MIX_FULL, MIX_RAILS, MIX_CLUSTER} level_mix_t;

  // Directed 3x3 frame: each channel has a median that differs from its center.
  localparam logic [0:8][7:0] BLUE_3X3  = {8'd9, 8'd1, 8'd8, 8'd2, 8'd7, 8'd3, 8'd6,
                                           8'd4, 8'd5};
  localparam logic [0:8][7:0] GREEN_3X3 = {8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255,
                                           8'd0, 8'd255, 8'd77};
  localparam logic [0:8][7:0] RED_3X3   = {8'd250, 8'd10, 8'd90, 8'd170, 8'd40, 8'd220,
                                           8'd130, 8'd60, 8'd200};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  res_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  median_filter_3x3_rgb u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_t  pixel_feed[$];
  res_t expected_pixels[$];
  int   mismatch_count = 0;
  int   result_index = 0;
  int   quiet_cycles = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  // ---------------------------------------------------------------- filter model
  logic [FW_FIELD_W-1:0] fw_reg;
  logic [FH_FIELD_W-1:0] fh_reg;
  pix_t line_mem [2*MAX_WIDTH];  // [0..] row above, [MAX_WIDTH..] two rows above
  pix_t win [3][3];
  int   in_col, in_row, out_col, out_row;

  function automatic int eff_cols();
    int w;
    w = fw_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_rows();
    int h;
    h = fh_reg;
    if (h < 3) h = 3;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic void restart_counters();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void reset_filter_model();
    int i, j;
    fw_reg = RST_FRAME_WIDTH;
    fh_reg = RST_FRAME_HEIGHT;
    for (i = 0; i < 2*MAX_WIDTH; i++) line_mem[i] = '0;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++) win[i][j] = '0;
    restart_counters();
  endfunction

  function automatic chan_t median_of_nine(input int ch);
    chan_t v [9];
    chan_t t;
    int i, j;
    for (i = 0; i < 9; i++) v[i] = win[i/3][i%3][ch];
    for (i = 1; i < 9; i++)
      for (j = i; j > 0 && v[j-1] > v[j]; j--) begin
        t      = v[j];
        v[j]   = v[j-1];
        v[j-1] = t;
      end
    return v[4];
  endfunction

  // Advances the filter by one accepted word; returns 1 when a result word is due.
  function automatic bit filter_pixel(input in_t word, output res_t res);
    int   cols, rows, col, r;
    bit   emit, on_border, last_px;
    pix_t px, up1, up2;
    cols = eff_cols();
    rows = eff_rows();
    res  = '0;
    if (in_row < rows) begin
      if (word.mode == MODE_FLUSH) return 1'b0;
      px[0] = word.chan0_in;
      px[1] = word.chan1_in;
      px[2] = word.chan2_in;
    end else begin
      // Draining: whatever arrives only pushes a zero pixel into the pipeline.
      px = '0;
    end
    col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
    up1 = line_mem[col];
    up2 = line_mem[MAX_WIDTH + col];
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = px;
    line_mem[MAX_WIDTH + col] = up1;
    line_mem[col]             = px;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= cols) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return 1'b0;
    on_border = out_row == 0 || out_row + 1 >= rows || out_col == 0 || out_col + 1 >= cols;
    if (on_border) begin
      res.chan0_out = win[1][1][0];
      res.chan1_out = win[1][1][1];
      res.chan2_out = win[1][1][2];
    end else begin
      res.chan0_out = median_of_nine(0);
      res.chan1_out = median_of_nine(1);
      res.chan2_out = median_of_nine(2);
    end
    last_px       = out_row + 1 >= rows && out_col + 1 >= cols;
    res.frame_end = last_px;
    if (last_px) begin
      restart_counters();
    end else begin
      out_col++;
      if (out_col >= cols) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic chan_t pick_level(input level_mix_t mix);
    case (mix)
      MIX_RAILS:   return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      MIX_CLUSTER: return 8'($urandom_range(126, 129));
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_t make_word(input logic mode, input chan_t b, input chan_t g,
                                    input chan_t r);
    in_t word;
    word.mode     = mode;
    word.chan0_in = b;
    word.chan1_in = g;
    word.chan2_in = r;
    return word;
  endfunction

  function automatic in_t random_word(input logic mode, input level_mix_t mix);
    return make_word(mode, pick_level(mix), pick_level(mix), pick_level(mix));
  endfunction

  // Queues count pixels of a frame with the odd ignored flush word among them, and
  // when asked the drain that follows the last pixel.
  task automatic queue_frame(input int cols, input int count, input bit drain);
    int k;
    level_mix_t mix;
    mix = level_mix_t'($urandom_range(0, 2));
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) pixel_feed.push_back(random_word(MODE_FLUSH, mix));
      pixel_feed.push_back(random_word(MODE_PIXEL, mix));
    end
    if (drain) begin
      // A pixel word during the drain acts as a flush word.
      for (k = 0; k <= cols; k++)
        pixel_feed.push_back(random_word($urandom_range(0, 3) == 0 ? MODE_PIXEL : MODE_FLUSH,
                                         MIX_FULL));
      if ($urandom_range(0, 3) == 0) pixel_feed.push_back(random_word(MODE_FLUSH, MIX_FULL));
    end
  endtask

  task automatic wait_for_idle();
    while (pixel_feed.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) fw_reg = val[FW_FIELD_W-1:0];
    else fh_reg = val;
    restart_counters();
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    // Keep the log short if the block is badly broken.
    if (mismatch_count <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- driver
  int in_gap = 0;
  bit calm_in = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pixel_feed.size() != 0) begin
        in_data  <= pixel_feed.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) == 0) calm_in = !calm_in;
        in_gap   <= draw_gap(calm_in);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int out_hold = 0;
  bit calm_out = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 99) == 0) calm_out = !calm_out;
        out_hold = draw_gap(calm_out);
      end
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold  = out_hold - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : monitor
    res_t pred;
    res_t want;
    in_fire  <= rst_n && in_valid && in_ready;
    out_fire <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      if (filter_pixel(in_data, pred)) expected_pixels.push_back(pred);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with none outstanding",
                                  result_index));
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.chan0_out !== want.chan0_out)
          report_mismatch($sformatf("word %0d blue: got %0h, expected %0h", result_index,
                                    out_data.chan0_out, want.chan0_out));
        if (out_data.chan1_out !== want.chan1_out)
          report_mismatch($sformatf("word %0d green: got %0h, expected %0h", result_index,
                                    out_data.chan1_out, want.chan1_out));
        if (out_data.chan2_out !== want.chan2_out)
          report_mismatch($sformatf("word %0d red: got %0h, expected %0h", result_index,
                                    out_data.chan2_out, want.chan2_out));
        if (out_data.frame_end !== want.frame_end)
          report_mismatch($sformatf("word %0d frame_end: got %0b, expected %0b",
                                    result_index, out_data.frame_end, want.frame_end));
      end
      result_index++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- test sequence
  initial begin : stimulus
    int k, f, cols, rows, count, nframes, small_pixels;
    bit full;
    logic [CFG_DATA_W-1:0] wval, hval;
    reset_filter_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size 640x480: extreme pixels lead into a partial frame, so the first
    // results are row 0 passed through.
    pixel_feed.push_back(make_word(MODE_PIXEL, 8'h00, 8'h00, 8'h00));
    pixel_feed.push_back(make_word(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    pixel_feed.push_back(make_word(MODE_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    pixel_feed.push_back(make_word(MODE_PIXEL, 8'h00, 8'hFF, 8'h00));
    pixel_feed.push_back(make_word(MODE_PIXEL, 8'hFF, 8'h00, 8'hFF));
    pixel_feed.push_back(make_word(MODE_PIXEL, 8'h55, 8'hAA, 8'h0F));
    pixel_feed.push_back(make_word(MODE_PIXEL, 8'hAA, 8'h55, 8'hF0));
    queue_frame(640, 660, 1'b0);
    wait_for_idle();

    // Sizes below the minimum clamp to 3x3; one full frame with a known median.
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    for (k = 0; k < 9; k++) begin
      pixel_feed.push_back(make_word(MODE_PIXEL, BLUE_3X3[k], GREEN_3X3[k], RED_3X3[k]));
      if (k == 3) pixel_feed.push_back(make_word(MODE_FLUSH, 8'h12, 8'h34, 8'h56));
    end
    pixel_feed.push_back(make_word(MODE_FLUSH, 8'h00, 8'h00, 8'h00));
    pixel_feed.push_back(make_word(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    pixel_feed.push_back(make_word(MODE_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    pixel_feed.push_back(make_word(MODE_FLUSH, 8'h00, 8'h00, 8'h00));
    // Frame done: this flush word has nothing to drain.
    pixel_feed.push_back(make_word(MODE_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    // A frame cut short, restarted by the next register write.
    for (k = 0; k < 5; k++)
      pixel_feed.push_back(make_word(MODE_PIXEL, GREEN_3X3[k], RED_3X3[k], BLUE_3X3[k]));
    wait_for_idle();

    // A height above the maximum clamps; a partial frame three pixels wide.
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    queue_frame(3, 60, 1'b0);
    wait_for_idle();

    // Small random sizes, one to three frames back to back per setting.
    small_pixels = 0;
    while (small_pixels < RANDOM_PIXELS) begin
      wval = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 2))
                                         : 13'($urandom_range(3, 24));
      wval[CFG_DATA_W-1] = 1'($urandom_range(0, 1));  // not part of the width field
      hval = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 2))
                                         : 13'($urandom_range(3, 10));
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_FRAME_WIDTH, wval);
        write_reg(CFG_FRAME_HEIGHT, hval);
      end else begin
        write_reg(CFG_FRAME_HEIGHT, hval);
        write_reg(CFG_FRAME_WIDTH, wval);
      end
      cols    = eff_cols();
      rows    = eff_rows();
      nframes = $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        full  = !(f == nframes - 1 && $urandom_range(0, 3) == 0);
        count = full ? cols * rows : $urandom_range(1, cols * rows - 1);
        queue_frame(cols, count, full);
        small_pixels += count;
      end
      wait_for_idle();
    end

    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
